### hdl/assert_macros.svh
// Assertion macros used by the checker module of the fade engine.
// Standalone header; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rlfe_pkg.sv
// Shared types and constants of the RGBW fade engine: opcodes, field
// widths, beat layouts and the status struct of the serial arithmetic unit.
// No dependencies.
`default_nettype none

package rlfe_pkg;

  localparam int OPCODE_BITS  = 2;
  localparam int CHANNEL_BITS = 3;
  localparam int FIELD_BITS   = 16;
  localparam int DUR_BITS     = 24;
  localparam int TIME_BITS    = 32;
  localparam int NCOL         = 4;

  localparam logic [OPCODE_BITS-1:0] OP_SET  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_FADE = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_TICK = 2'd2;

  // input beat: channel, red, green, blue, white, duration, time
  localparam int CH_LSB      = 0;
  localparam int COL_LSB     = CH_LSB + CHANNEL_BITS;
  localparam int DUR_LSB     = COL_LSB + NCOL * FIELD_BITS;
  localparam int TIME_LSB    = DUR_LSB + DUR_BITS;
  localparam int S_DATA_BITS = ((TIME_LSB + TIME_BITS + 7) / 8) * 8;

  // output beat: channel, red, green, blue, white
  localparam int M_DATA_BITS = ((COL_LSB + NCOL * FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } md_stat_t;

endpackage

`default_nettype wire

### hdl/rlfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; no reset on the storage.
`default_nettype none

module rlfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/rlfe_muldiv.sv
// Serial unit for floor(e * mag / len): shift-add multiply, then restoring
// divide, one bit per cycle in a shared shift register. Uses rlfe_pkg.
`default_nettype none

module rlfe_muldiv #(
  parameter int MAG_BITS = 17
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire  [rlfe_pkg::DUR_BITS-1:0]  e,
  input  wire  [rlfe_pkg::DUR_BITS-1:0]  len,
  input  wire  [MAG_BITS-1:0]            mag,
  output logic [MAG_BITS-1:0]            quot,
  output rlfe_pkg::md_stat_t             stat
);
  import rlfe_pkg::*;

  localparam int PW   = DUR_BITS + MAG_BITS;
  localparam int CNTW = $clog2(MAG_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]          st;
  logic [CNTW-1:0]     cnt;
  logic                done;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       prod_next;
  logic [DUR_BITS:0]   sum;
  logic [DUR_BITS:0]   trial;
  logic [DUR_BITS:0]   rem_sub;
  logic                ge;
  logic                last_bit;

  assign last_bit = (cnt == CNTW'(MAG_BITS - 1));

  always_comb begin
    sum     = {1'b0, prod[PW-1:MAG_BITS]} + (prod[0] ? {1'b0, e} : '0);
    trial   = {prod[PW-1:MAG_BITS], prod[MAG_BITS-1]};
    ge      = (trial >= {1'b0, len});
    rem_sub = trial - {1'b0, len};
    case (st)
      S_MUL:   prod_next = {sum, prod[MAG_BITS-1:1]};
      S_DIV:   prod_next = {(ge ? rem_sub[DUR_BITS-1:0] : trial[DUR_BITS-1:0]),
                            prod[MAG_BITS-2:0], ge};
      default: prod_next = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            st  <= S_MUL;
            cnt <= '0;
          end
        end
        S_MUL: begin
          cnt <= last_bit ? '0 : cnt + 1'b1;
          if (last_bit) begin
            st <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= last_bit ? '0 : cnt + 1'b1;
          if (last_bit) begin
            st   <= S_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_IDLE && start) begin
      prod <= {{DUR_BITS{1'b0}}, mag};
    end else begin
      prod <= prod_next;
    end
  end

  // remainder sits in the top, quotient in the bottom once the divide is over
  assign quot        = prod[MAG_BITS-1:0];
  assign stat.done   = done;
  assign stat.rem_nz = |prod[PW-1:MAG_BITS];

endmodule

`default_nettype wire

### hdl/rgbw_linear_fade_engine.sv
// RGBW fade engine top level. Set beat: four colour writes. Fade beat: read and
// write per colour. Tick beat: taken, then per channel colours copied if idle,
// computed if fading (serial multiply and divide, one bit per cycle, four
// colours in turn), plus any wait for the output slot; one beat at a time.
// Synchronous reset clears control and valid flags; no RAM sweep.
`default_nettype none

// Depends on rlfe_pkg, rlfe_ram and rlfe_muldiv.
//
// Storage:
//   colour RAM  : per colour {delta, start, current}, address {channel, colour}
//   channel RAM : per channel {start time, fade length}
//   flops       : fading flag and written flag per channel; an unwritten
//                 channel reads as zero colours.
// Output beats sit in a register, so the next input beat is taken while the
// last beat of a frame still waits for the sink.

module rgbw_linear_fade_engine #(
  parameter int CHANNELS    = 8,
  parameter int COLOUR_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel, red, green, blue, white, duration, time_ms, zero pad
  input  wire  [rlfe_pkg::S_DATA_BITS-1:0]    s_axis_tdata,
  // opcode
  input  wire  [rlfe_pkg::OPCODE_BITS-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // out_channel, out_red, out_green, out_blue, out_white, zero pad
  output logic [rlfe_pkg::M_DATA_BITS-1:0]    m_axis_tdata,
  // last
  output logic                                m_axis_tlast
);
  import rlfe_pkg::*;

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CB   = COLOUR_BITS;
  localparam int MB   = CB + 1;             // delta / magnitude width
  localparam int WW   = 3 * CB + 1;         // colour word
  localparam int AW   = CW + 2;
  localparam int XW   = CW + CHANNEL_BITS;  // channel field widened
  localparam int VW   = CB + 3;             // signed result before clamp
  localparam int CHW  = TIME_BITS + DUR_BITS;

  localparam logic [XW-1:0] CH_LIMIT = XW'(CHANNELS);
  localparam logic [CW-1:0] CH_LAST  = CW'(CHANNELS - 1);
  localparam logic [1:0]    K_LAST   = 2'(NCOL - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SET  = 4'd1;   // write four colours
  localparam logic [3:0] ST_FRD  = 4'd2;   // fade: read current colour
  localparam logic [3:0] ST_FWR  = 4'd3;   // fade: write start and delta
  localparam logic [3:0] ST_TCH  = 4'd4;   // tick: read channel timing
  localparam logic [3:0] ST_TEL  = 4'd5;   // elapsed time
  localparam logic [3:0] ST_TCMP = 4'd6;   // clip elapsed, end fade
  localparam logic [3:0] ST_TRD  = 4'd7;   // read colour word
  localparam logic [3:0] ST_TLD  = 4'd8;   // start arithmetic or copy
  localparam logic [3:0] ST_TCALC = 4'd9;  // wait on serial unit
  localparam logic [3:0] ST_TWB  = 4'd10;  // write back new colour
  localparam logic [3:0] ST_TOUT = 4'd11;  // hand beat to output register

  logic [3:0]          state;
  logic [CHANNELS-1:0] fading;
  logic [CHANNELS-1:0] col_valid;
  logic [CW-1:0]       cmd_idx;
  logic [CW-1:0]       ch_cnt;
  logic [1:0]          kidx;
  logic                cvalid_snap;
  logic                act;
  logic                neg_r;
  logic [CB-1:0]       col_in [NCOL];
  logic [CB-1:0]       asm_col [NCOL];
  logic [TIME_BITS-1:0] cmd_time;
  logic [TIME_BITS-1:0] el;
  logic [DUR_BITS-1:0] len_r;
  logic [DUR_BITS-1:0] e_r;
  logic [WW-1:0]       word;

  // input decode
  logic                 s_acc;
  logic [XW-1:0]        in_chan_x;
  logic [CW-1:0]        in_idx;
  logic                 in_range;
  logic [DUR_BITS-1:0]  in_dur;
  logic [TIME_BITS-1:0] in_time;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign in_chan_x = {{CW{1'b0}}, s_axis_tdata[CH_LSB +: CHANNEL_BITS]};
  assign in_idx    = in_chan_x[CW-1:0];
  assign in_range  = (in_chan_x < CH_LIMIT);
  assign in_dur    = s_axis_tdata[DUR_LSB +: DUR_BITS];
  assign in_time   = s_axis_tdata[TIME_LSB +: TIME_BITS];

  // channel RAM: written straight from the accepted fade beat
  logic           chan_we;
  logic [CHW-1:0] chan_rdata;

  assign chan_we = s_acc && (s_axis_tuser == OP_FADE) && in_range;

  rlfe_ram #(.WIDTH(CHW), .DEPTH(2 ** CW)) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (in_idx),
    .wdata ({in_time, in_dur}),
    .raddr (ch_cnt),
    .rdata (chan_rdata)
  );

  // colour RAM
  logic          col_we;
  logic [AW-1:0] col_waddr;
  logic [AW-1:0] col_raddr;
  logic [WW-1:0] col_wdata;
  logic [WW-1:0] col_rdata;
  logic [CB-1:0] fade_cur;
  logic [MB-1:0] fade_dist;
  logic [CB-1:0] new_col;

  rlfe_ram #(.WIDTH(WW), .DEPTH(2 ** AW)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // serial multiply-divide
  logic          md_start;
  logic [MB-1:0] md_mag;
  logic [MB-1:0] md_quot;
  md_stat_t      md_stat;
  logic [MB-1:0] rd_delta;

  assign rd_delta = col_rdata[WW-1:2*CB];
  assign md_start = (state == ST_TLD) && act;
  assign md_mag   = rd_delta[MB-1] ? (MB'(0) - rd_delta) : rd_delta;

  rlfe_muldiv #(.MAG_BITS(MB)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .e     (e_r),
    .len   (len_r),
    .mag   (md_mag),
    .quot  (md_quot),
    .stat  (md_stat)
  );

  // new colour = start + floor(e * delta / len); a negative delta rounds
  // the magnitude up when the divide leaves a remainder
  logic [MB:0]   qmag;
  logic [VW-1:0] sv;

  always_comb begin
    qmag = {1'b0, md_quot} + {{MB{1'b0}}, neg_r & md_stat.rem_nz};
    sv   = VW'(word[2*CB-1:CB]) + (neg_r ? (VW'(0) - VW'(qmag)) : VW'(qmag));
    if (sv[VW-1]) begin
      new_col = '0;
    end else if (sv[VW-2:CB] != '0) begin
      new_col = '1;
    end else begin
      new_col = sv[CB-1:0];
    end
  end

  always_comb begin
    fade_cur   = cvalid_snap ? col_rdata[CB-1:0] : '0;
    fade_dist  = MB'(col_in[kidx]) - MB'(fade_cur);
    col_raddr  = (state == ST_FRD) ? {cmd_idx, kidx} : {ch_cnt, kidx};
    col_we     = 1'b0;
    col_waddr  = {ch_cnt, kidx};
    col_wdata  = {word[WW-1:CB], new_col};
    case (state)
      ST_SET: begin
        // start and delta are dead until the next fade rewrites them
        col_we    = 1'b1;
        col_waddr = {cmd_idx, kidx};
        col_wdata = {{(2 * CB + 1){1'b0}}, col_in[kidx]};
      end
      ST_FWR: begin
        col_we    = 1'b1;
        col_waddr = {cmd_idx, kidx};
        col_wdata = {fade_dist, fade_cur, fade_cur};
      end
      ST_TWB: begin
        col_we = 1'b1;
      end
      default: ;
    endcase
  end

  // output beat assembly
  logic                   out_free;
  logic [XW-1:0]          ch_cnt_x;
  logic [M_DATA_BITS-1:0] out_data;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ch_cnt_x = {{CHANNEL_BITS{1'b0}}, ch_cnt};

  always_comb begin
    out_data = '0;
    out_data[CH_LSB +: CHANNEL_BITS] = ch_cnt_x[CHANNEL_BITS-1:0];
    for (int k = 0; k < NCOL; k++) begin
      out_data[COL_LSB + k * FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(asm_col[k]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fading        <= '0;
      col_valid     <= '0;
      kidx          <= '0;
      ch_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a new beat fills the slot, else a taken beat empties it
      if (state == ST_TOUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            kidx <= '0;
            case (s_axis_tuser)
              OP_SET: begin
                if (in_range) begin
                  fading[in_idx]    <= 1'b0;
                  col_valid[in_idx] <= 1'b1;
                  state             <= ST_SET;
                end
              end
              OP_FADE: begin
                if (in_range) begin
                  fading[in_idx]    <= (in_dur != '0);
                  col_valid[in_idx] <= 1'b1;
                  state             <= ST_FRD;
                end
              end
              OP_TICK: begin
                ch_cnt <= '0;
                state  <= ST_TCH;
              end
              default: ;
            endcase
          end
        end
        ST_SET: begin
          kidx <= kidx + 1'b1;
          if (kidx == K_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_FRD: state <= ST_FWR;
        ST_FWR: begin
          kidx  <= kidx + 1'b1;
          state <= (kidx == K_LAST) ? ST_IDLE : ST_FRD;
        end
        ST_TCH: begin
          kidx  <= '0;
          state <= fading[ch_cnt] ? ST_TEL : ST_TRD;
        end
        ST_TEL: state <= ST_TCMP;
        ST_TCMP: begin
          // past the end: clip to the target and drop the fade
          if (el > TIME_BITS'(len_r)) begin
            fading[ch_cnt] <= 1'b0;
          end
          state <= ST_TRD;
        end
        ST_TRD: state <= ST_TLD;
        ST_TLD: begin
          if (act) begin
            state <= ST_TCALC;
          end else begin
            kidx  <= kidx + 1'b1;
            state <= (kidx == K_LAST) ? ST_TOUT : ST_TRD;
          end
        end
        ST_TCALC: begin
          if (md_stat.done) begin
            state <= ST_TWB;
          end
        end
        ST_TWB: begin
          kidx  <= kidx + 1'b1;
          state <= (kidx == K_LAST) ? ST_TOUT : ST_TRD;
        end
        ST_TOUT: begin
          if (out_free) begin
            if (ch_cnt == CH_LAST) begin
              state <= ST_IDLE;
            end else begin
              ch_cnt <= ch_cnt + 1'b1;
              state  <= ST_TCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_acc) begin
      cmd_idx     <= in_idx;
      cmd_time    <= in_time;
      cvalid_snap <= col_valid[in_idx];
      for (int k = 0; k < NCOL; k++) begin
        col_in[k] <= CB'(s_axis_tdata[COL_LSB + k * FIELD_BITS +: FIELD_BITS]);
      end
    end
    if (state == ST_TCH) begin
      act <= fading[ch_cnt];
    end
    if (state == ST_TEL) begin
      el    <= cmd_time - chan_rdata[CHW-1:DUR_BITS];
      len_r <= chan_rdata[DUR_BITS-1:0];
    end
    if (state == ST_TCMP) begin
      e_r <= (el > TIME_BITS'(len_r)) ? len_r : el[DUR_BITS-1:0];
    end
    if (state == ST_TLD) begin
      word  <= col_rdata;
      neg_r <= rd_delta[MB-1];
      if (!act) begin
        asm_col[kidx] <= col_valid[ch_cnt] ? col_rdata[CB-1:0] : '0;
      end
    end
    if (state == ST_TWB) begin
      asm_col[kidx] <= new_col;
    end
    if (state == ST_TOUT && out_free) begin
      m_axis_tdata <= out_data;
      m_axis_tlast <= (ch_cnt == CH_LAST);
    end
  end

endmodule

`default_nettype wire

### hdl/rlfe_checker.sv
// Port-level checks on the fade engine, bound to the top level.
// Uses rlfe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rlfe_checker #(
  parameter int CHANNELS = 8
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire [rlfe_pkg::OPCODE_BITS-1:0]  s_axis_tuser,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [rlfe_pkg::M_DATA_BITS-1:0]  m_axis_tdata,
  input wire                              m_axis_tlast
);
  import rlfe_pkg::*;

  // the frame closes on the highest channel
  `ASSERT_IMPLY(a_last_chan, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[CHANNEL_BITS-1:0] == CHANNEL_BITS'(CHANNELS - 1), "last beat on wrong channel")

  // a stalled beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

  // a tick starts a frame, so input closes
  `ASSERT_NEXT(a_tick_busy, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK, !s_axis_tready, "input open right after a tick")

  // mid-frame beats never coexist with an open input
  `ASSERT_IMPLY(a_frame_busy, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input open during a frame")

endmodule

bind rgbw_linear_fade_engine rlfe_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

`default_nettype wire
